### hw/rtl/pls_pkg.sv
package pls_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int TOT_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_INS_AT,
        OP_INS_FRONT,
        OP_INS_BACK,
        OP_REM_AT,
        OP_REM_FRONT,
        OP_REM_BACK
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_RANGE,
        ST_EMPTY,
        ST_FULL
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [CMP_W-1:0]  pos;
        logic [DATA_W-1:0] data;
    } cell_cmd_t;

    typedef struct packed {
        logic             rd_en;
        logic [CMP_W-1:0] rd_pos;
        logic             has_back;
        logic [CMP_W-1:0] back_pos;
    } cell_tap_t;

    typedef struct packed {
        logic [2:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [1:0]              status;
        logic [TOT_W-1:0]        element_total;
        logic                    is_empty;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
    } rsp_t;

    function automatic logic [DATA_W-1:0] to_cell(input logic signed [VAL_W-1:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        return w[DATA_W-1:0];
    endfunction

    function automatic logic signed [VAL_W-1:0] from_cell(input logic [DATA_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(signed'(v));
        return w[VAL_W-1:0];
    endfunction

endpackage

### hw/rtl/positional_list_store.sv
// Ordered list of signed values held in a row of cells, one entry per cell,
// packed at positions 0 to count-1.
// Request channel: req_valid, req_stall, req (operation, position, value).
// Response channel: rsp_valid, rsp_stall, rsp (read_value, status,
// element_total, is_empty, front_value, back_value).
// An item is taken at an edge with valid high and stall low.
// Every request gives exactly one response, in order.
// A request's response enters the response register once that register is
// free, and the next request cannot be taken before then. At the taking edge
// all cells shift or load at once; after it the cell read taps are combined
// into the response register.
// req_stall is high in the cycle after a request is taken, and stays high
// while that response cannot enter the response register.
// A response held by rsp_stall stays in its register and does not block the
// next request.
// Reset clears the count (empty list) and both valid flags; cell contents
// are not cleared and are only read below the count.
module positional_list_store
    import pls_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic              acc;
    logic              load;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              pend_reg;
    logic              pend_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    status_t           stat_reg;
    status_t           stat_next;
    cell_tap_t         tap_reg;
    cell_tap_t         tap_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    cell_cmd_t         cmd;

    op_t               op;
    logic [CMP_W-1:0]  nn;
    logic [CMP_W-1:0]  p_in;
    logic [CMP_W-1:0]  p_eff;
    logic [CNT_W-1:0]  cnt_new;

    logic [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0] rd_taps  [CAPACITY];
    logic [DATA_W-1:0] bk_taps  [CAPACITY];
    logic [DATA_W-1:0] rd_any;
    logic [DATA_W-1:0] bk_any;

    assign acc       = req_valid && !req_stall;
    assign req_stall = pend_reg;
    assign load      = pend_reg && (!rsp_valid_reg || !rsp_stall);

    assign op   = op_t'(req.operation);
    assign nn   = CMP_W'(count_reg);
    assign p_in = CMP_W'(req.position);

    always_comb
    begin
        stat_next = ST_OK;
        cnt_new   = count_reg;
        p_eff     = p_in;
        cmd.op    = CELL_HOLD;
        cmd.pos   = p_in;
        cmd.data  = to_cell(req.value);
        tap_next  = tap_reg;
        tap_next.rd_en = 1'b0;
        case (op)
            OP_READ, OP_WRITE:
            begin
                if (p_in >= nn)
                begin
                    stat_next = ST_RANGE;
                end
                else if (op == OP_WRITE)
                begin
                    cmd.op = CELL_WRITE;
                end
                else
                begin
                    tap_next.rd_en = 1'b1;
                end
            end
            OP_INS_AT, OP_INS_FRONT, OP_INS_BACK:
            begin
                if (op == OP_INS_FRONT)
                begin
                    p_eff = '0;
                end
                else if (op == OP_INS_BACK)
                begin
                    p_eff = nn;
                end
                if (p_eff > nn)
                begin
                    stat_next = ST_RANGE;
                end
                else if (nn >= CMP_W'(CAPACITY))
                begin
                    stat_next = ST_FULL;
                end
                else
                begin
                    cmd.op  = CELL_INSERT;
                    cnt_new = count_reg + CNT_W'(1);
                end
            end
            default:
            begin
                if (op == OP_REM_FRONT)
                begin
                    p_eff = '0;
                end
                else if (op == OP_REM_BACK)
                begin
                    p_eff = nn - CMP_W'(1);
                end
                if (nn == '0)
                begin
                    stat_next = ST_EMPTY;
                end
                else if (p_eff >= nn)
                begin
                    stat_next = ST_RANGE;
                end
                else
                begin
                    cmd.op  = CELL_REMOVE;
                    cnt_new = count_reg - CNT_W'(1);
                end
            end
        endcase
        cmd.pos           = p_eff;
        tap_next.rd_pos   = p_in;
        tap_next.has_back = (cnt_new != '0);
        tap_next.back_pos = CMP_W'(cnt_new) - CMP_W'(1);
        if (!acc)
        begin
            cmd.op    = CELL_HOLD;
            cnt_new   = count_reg;
            stat_next = stat_reg;
            tap_next  = tap_reg;
        end
        count_next = cnt_new;
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] lft;
        logic [DATA_W-1:0] rgt;
        if (i == 0)
        begin : g_first
            assign lft = '0;
        end
        else
        begin : g_mid_l
            assign lft = cell_val[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_last
            assign rgt = '0;
        end
        else
        begin : g_mid_r
            assign rgt = cell_val[i+1];
        end
        pls_cell u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .tap      (tap_reg),
            .idx      (CMP_W'(i)),
            .left     (lft),
            .right    (rgt),
            .val      (cell_val[i]),
            .rd_tap   (rd_taps[i]),
            .back_tap (bk_taps[i])
        );
    end

    always_comb
    begin
        rd_any = '0;
        bk_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | rd_taps[i];
            bk_any = bk_any | bk_taps[i];
        end
    end

    always_comb
    begin
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (load)
        begin
            pend_next              = 1'b0;
            rsp_valid_next         = 1'b1;
            rsp_next.read_value    = from_cell(rd_any);
            rsp_next.status        = stat_reg;
            rsp_next.element_total = TOT_W'(count_reg);
            rsp_next.is_empty      = (count_reg == '0);
            rsp_next.front_value   = tap_reg.has_back ? from_cell(cell_val[0]) : '0;
            rsp_next.back_value    = from_cell(bk_any);
        end
        if (acc)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
        tap_reg  <= tap_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !acc |=> $stable(count_reg))
        else $error("count changed without a request");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (cmd.op == CELL_INSERT) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the list");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.is_empty |-> (rsp.front_value == '0) && (rsp.back_value == '0)
            && (rsp.element_total == '0))
        else $error("empty response carries data");

endmodule

### hw/rtl/pls_cell.sv
module pls_cell
    import pls_pkg::*;
(
    input  logic              clk,
    input  cell_cmd_t         cmd,
    input  cell_tap_t         tap,
    input  logic [CMP_W-1:0]  idx,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] val,
    output logic [DATA_W-1:0] rd_tap,
    output logic [DATA_W-1:0] back_tap
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (cmd.op)
            CELL_WRITE:
            begin
                if (idx == cmd.pos)
                begin
                    val_next = cmd.data;
                end
            end
            CELL_INSERT:
            begin
                if (idx > cmd.pos)
                begin
                    val_next = left;
                end
                else if (idx == cmd.pos)
                begin
                    val_next = cmd.data;
                end
            end
            CELL_REMOVE:
            begin
                if (idx >= cmd.pos)
                begin
                    val_next = right;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val      = val_reg;
    assign rd_tap   = (tap.rd_en && (idx == tap.rd_pos)) ? val_reg : '0;
    assign back_tap = (tap.has_back && (idx == tap.back_pos)) ? val_reg : '0;

endmodule

### verif/tb_positional_list_store.sv
module tb_positional_list_store;
    import pls_pkg::*;

    localparam int RANDOM_ITEMS   = 1830;
    localparam int SCRIPT_LEN     = 24;
    localparam int PRESSURE_AT    = 400;
    localparam int PRESSURE_HOLD  = 80;
    localparam int DRAIN_CYCLES   = 10;
    localparam int QUIET_LIMIT    = 2000;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        op_t                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        bit                      typed;
        rsp_t                    want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    logic signed [DATA_W-1:0] mirror_cells [CAPACITY];
    int   mirror_count = 0;
    bit   growing = 1'b1;
    rsp_t pending_rsp [$];

    int   accepted_reqs = 0;
    int   checked_rsps = 0;
    int   mismatch_count = 0;
    int   quiet_cycles = 0;
    int   status_seen [4] = '{0, 0, 0, 0};
    bit   pressure_done = 1'b0;

    script_row_t script [SCRIPT_LEN] = '{
        '{OP_READ,      7'd0,   32'sd0,       1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_WRITE,     7'd0,   32'sd5,       1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_REM_AT,    7'd127, 32'sd0,       1'b1, '{32'sd0, ST_EMPTY, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_REM_FRONT, 7'd0,   32'sd0,       1'b1, '{32'sd0, ST_EMPTY, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_REM_BACK,  7'd0,   32'sd0,       1'b1, '{32'sd0, ST_EMPTY, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_INS_AT,    7'd1,   32'sd9,       1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_INS_AT,    7'd127, 32'sd9,       1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1, 32'sd0, 32'sd0}},
        '{OP_INS_FRONT, 7'd0,   VAL_MIN,      1'b1, '{32'sd0, ST_OK, 7'd1, 1'b0, VAL_MIN, VAL_MIN}},
        '{OP_INS_BACK,  7'd127, VAL_MAX,      1'b1, '{32'sd0, ST_OK, 7'd2, 1'b0, VAL_MIN, VAL_MAX}},
        '{OP_READ,      7'd0,   32'sd0,       1'b1, '{VAL_MIN, ST_OK, 7'd2, 1'b0, VAL_MIN, VAL_MAX}},
        '{OP_READ,      7'd1,   32'sd0,       1'b1, '{VAL_MAX, ST_OK, 7'd2, 1'b0, VAL_MIN, VAL_MAX}},
        '{OP_READ,      7'd2,   32'sd0,       1'b1, '{32'sd0, ST_RANGE, 7'd2, 1'b0, VAL_MIN, VAL_MAX}},
        '{OP_INS_AT,    7'd1,   -32'sd1,      1'b0, '0},
        '{OP_INS_AT,    7'd3,   32'sd0,       1'b0, '0},
        '{OP_INS_AT,    7'd5,   32'sd7,       1'b0, '0},
        '{OP_WRITE,     7'd0,   32'sh5555_aaaa, 1'b0, '0},
        '{OP_WRITE,     7'd4,   32'sd3,       1'b0, '0},
        '{OP_READ,      7'd1,   32'sd0,       1'b0, '0},
        '{OP_REM_AT,    7'd4,   32'sd0,       1'b0, '0},
        '{OP_REM_AT,    7'd1,   32'sd0,       1'b0, '0},
        '{OP_REM_FRONT, 7'd0,   32'sd0,       1'b0, '0},
        '{OP_REM_BACK,  7'd0,   32'sd0,       1'b0, '0},
        '{OP_REM_AT,    7'd0,   32'sd0,       1'b0, '0},
        '{OP_READ,      7'd0,   32'sd0,       1'b1, '{32'sd0, ST_RANGE, 7'd0, 1'b1, 32'sd0, 32'sd0}}
    };

    positional_list_store i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic rsp_t list_apply(input req_t item);
        rsp_t res;
        op_t  op;
        int   pos;
        int   n;
        int   i;
        res = '0;
        res.status = ST_OK;
        op = op_t'(item.operation);
        n = mirror_count;
        pos = item.position;
        case (op)
            OP_READ, OP_WRITE:
            begin
                if (pos >= n)
                    res.status = ST_RANGE;
                else if (op == OP_READ)
                    res.read_value = mirror_cells[pos];
                else
                    mirror_cells[pos] = item.value[DATA_W-1:0];
            end
            OP_INS_AT, OP_INS_FRONT, OP_INS_BACK:
            begin
                if (op == OP_INS_FRONT)
                    pos = 0;
                if (op == OP_INS_BACK)
                    pos = n;
                if (pos > n)
                    res.status = ST_RANGE;
                else if (n >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (i = n; i > pos; i--)
                        mirror_cells[i] = mirror_cells[i-1];
                    mirror_cells[pos] = item.value[DATA_W-1:0];
                    mirror_count++;
                end
            end
            default:
            begin
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    if (op == OP_REM_FRONT)
                        pos = 0;
                    if (op == OP_REM_BACK)
                        pos = n - 1;
                    if (pos >= n)
                        res.status = ST_RANGE;
                    else
                    begin
                        for (i = pos; i + 1 < n; i++)
                            mirror_cells[i] = mirror_cells[i+1];
                        mirror_count--;
                    end
                end
            end
        endcase
        n = mirror_count;
        res.element_total = TOT_W'(n);
        res.is_empty = (n == 0);
        if (n != 0)
        begin
            res.front_value = mirror_cells[0];
            res.back_value = mirror_cells[n-1];
        end
        return res;
    endfunction

    // bias toward filling or draining so both full and empty lists are reached
    function automatic req_t random_request();
        req_t item;
        int   r;
        int   sub;
        bit   take_insert;
        if (growing && mirror_count == CAPACITY && $urandom_range(0, 5) == 0)
            growing = 1'b0;
        else if (!growing && mirror_count == 0 && $urandom_range(0, 5) == 0)
            growing = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 15)
            item.operation = OP_READ;
        else if (r < 25)
            item.operation = OP_WRITE;
        else
        begin
            sub = $urandom_range(0, 3);
            take_insert = ((r < 80) == growing);
            if (take_insert)
                item.operation = (sub < 2) ? OP_INS_AT : ((sub == 2) ? OP_INS_FRONT : OP_INS_BACK);
            else
                item.operation = (sub < 2) ? OP_REM_AT : ((sub == 2) ? OP_REM_FRONT : OP_REM_BACK);
        end
        case ($urandom_range(0, 9))
            0: item.position = POS_W'($urandom_range(0, 127));
            1: item.position = POS_W'((mirror_count + 2 > 127) ? 127 :
                                      mirror_count + $urandom_range(0, 2));
            default: item.position = POS_W'($urandom_range(0, mirror_count));
        endcase
        case ($urandom_range(0, 19))
            0: item.value = VAL_MIN;
            1: item.value = VAL_MAX;
            2: item.value = '0;
            3: item.value = -32'sd1;
            default: item.value = $urandom;
        endcase
        return item;
    endfunction

    function automatic int pick_gap(input int idx);
        int r;
        if ((idx % 300) < 60)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic bit field_differs(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got === want)
            return 1'b0;
        $display("%0t: %s expected 0x%08h got 0x%08h", $time, name, want, got);
        return 1'b1;
    endfunction

    initial
    begin
        req_t item;
        int   gap;
        int   idx;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (idx = 0; idx < SCRIPT_LEN + RANDOM_ITEMS; idx++)
        begin
            if (idx < SCRIPT_LEN)
            begin
                item.operation = script[idx].op;
                item.position = script[idx].pos;
                item.value = script[idx].val;
            end
            else
                item = random_request();
            gap = pick_gap(idx);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req <= item;
            req_valid <= 1'b1;
            @(posedge clk);
            while (req_stall)
                @(posedge clk);
            accepted_reqs++;
            if (idx < SCRIPT_LEN && script[idx].typed)
            begin
                void'(list_apply(item));
                pending_rsp.push_back(script[idx].want);
            end
            else
                pending_rsp.push_back(list_apply(item));
        end
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d list operations, %0d responses checked, %0d mismatches.",
                 accepted_reqs, checked_rsps, mismatch_count);
        $display("Statuses seen: ok %0d, out of range %0d, empty %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_EMPTY],
                 status_seen[ST_FULL]);
        if (mismatch_count == 0 && pending_rsp.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int run;
        int hold;
        rsp_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
            repeat (run) @(posedge clk);
            // hold off long enough for the block to back up into its input
            if (!pressure_done && accepted_reqs >= PRESSURE_AT)
            begin
                pressure_done = 1'b1;
                hold = PRESSURE_HOLD;
            end
            else
                hold = pick_stall();
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        rsp_t want;
        bit   bad;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                checked_rsps++;
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response with nothing expected, got %h", $time, rsp);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    bad = field_differs("read_value", want.read_value, rsp.read_value)
                        | field_differs("status", 32'(want.status), 32'(rsp.status))
                        | field_differs("element_total", 32'(want.element_total),
                                        32'(rsp.element_total))
                        | field_differs("is_empty", 32'(want.is_empty), 32'(rsp.is_empty))
                        | field_differs("front_value", want.front_value, rsp.front_value)
                        | field_differs("back_value", want.back_value, rsp.back_value);
                    if (bad)
                        mismatch_count++;
                    status_seen[rsp.status]++;
                end
            end
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
